FILE: rtl/core/mfdl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfdl_pkg
// Shared constants and types for the modulated fractional delay line.
// ----------------------------------------------------------------------------
package mfdl_pkg;

    localparam int STORE_DEPTH_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int MOD_BITS       = 16;
    localparam int CENTER_BITS    = 18;
    localparam int DEPTH_BITS     = 18;
    localparam int GAIN_BITS      = 16;
    localparam int WET_BITS       = 17;
    localparam int CFG_DATA_BITS  = 18;
    localparam int CFG_INDEX_BITS = 2;
    localparam int FRAC_BITS      = 8;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DELAY_CENTER  = 2'd0,
        CFG_DELAY_DEPTH   = 2'd1,
        CFG_FEEDBACK_GAIN = 2'd2,
        CFG_WET_MIX       = 2'd3
    } cfg_index_t;

endpackage

FILE: rtl/core/mfdl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfdl_ram
// Generic RAM: one write port, two registered read ports, read-first.
// ----------------------------------------------------------------------------
module mfdl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // reads return the old contents when the same entry is written
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: rtl/core/modulated_fractional_delay_line.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modulated_fractional_delay_line
// Modulated delay with linear interpolation, feedback and dry/wet mix.
// ----------------------------------------------------------------------------
// One item (audio sample plus modulation value) is taken at a time: a
// sequencer walks each item through the delay product, the store access (two
// interpolation reads and the feedback write, issued together on the delay RAM),
// the interpolation product, the wet product and the final mix. The next item
// is taken while the previous result still waits on the output register; the
// sequencer holds in its last step only if that register is still full. The
// store reads as zero after reset without a clearing pass: entries not yet
// reached by the write position read as zero until the position first wraps.
// The user must write registers only while no item is in flight (unchecked).
module modulated_fractional_delay_line #(
    parameter int STORE_DEPTH = mfdl_pkg::STORE_DEPTH_DEF,
    parameter int SAMPLE_BITS = mfdl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_we,
    input  logic [mfdl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mfdl_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // input items
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata: audio_in [SAMPLE_BITS], modulation [16], zero fill
    input  logic [((SAMPLE_BITS+mfdl_pkg::MOD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // result items
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // tdata: audio_out [SAMPLE_BITS], zero fill
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);

    import mfdl_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int DSW   = (AW + 9 > 21) ? AW + 9 : 21;
    localparam int RPW   = AW + FRAC_BITS + 1;

    localparam logic signed [DSW-1:0] MAX_DELAY = DSW'((STORE_DEPTH - 1) * 256);
    localparam logic [RPW-1:0]        STORE_SPAN = RPW'(STORE_DEPTH * 256);
    localparam logic [AW-1:0]         LAST_IDX   = AW'(STORE_DEPTH - 1);

    localparam longint SMP_MAX = (64'sd1 <<< (SB - 1)) - 1;
    localparam logic signed [SB+1:0] FB_MAX  = (SB+2)'(SMP_MAX);
    localparam logic signed [SB+1:0] FB_MIN  = ~FB_MAX;
    localparam logic signed [SB+2:0] MIX_MAX = (SB+3)'(SMP_MAX);
    localparam logic signed [SB+2:0] MIX_MIN = ~MIX_MAX;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DLY,
        S_ADDR,
        S_RD,
        S_WET,
        S_OUT
    } state_t;

    // configuration registers
    logic [CENTER_BITS-1:0] center_reg;
    logic [DEPTH_BITS-1:0]  depth_reg;
    logic [GAIN_BITS-1:0]   gain_reg;
    logic [WET_BITS-1:0]    wet_mix_reg;

    // sequencer and datapath registers
    state_t                    state_reg;
    logic signed [SB-1:0]      audio_reg;
    logic signed [MOD_BITS-1:0] mod_reg;
    logic signed [19:0]        dsh_reg;
    logic signed [SB:0]        fbsh_reg;
    logic signed [SB+17:0]     dry_prod_reg;
    logic [AW-1:0]             wp_reg;
    logic                      wrapped_reg;
    logic                      v0_reg;
    logic                      v1_reg;
    logic [FRAC_BITS-1:0]      frac_reg;
    logic signed [SB-1:0]      s0_reg;
    logic signed [SB+9:0]      iprod_reg;
    logic signed [SB+17:0]     wet_prod_reg;
    logic signed [SB-1:0]      last_reg;
    logic                      out_valid_reg;
    logic [SB-1:0]             out_data_reg;

    // combinational
    logic                      in_accept;
    logic signed [MOD_BITS+DEPTH_BITS:0] dprod;
    logic signed [SB+16:0]     fbprod;
    logic signed [17:0]        dry_share;
    logic signed [SB+17:0]     dry_prod;
    logic signed [DSW-1:0]     delay_sum;
    logic signed [DSW-1:0]     delay_clamp;
    logic [RPW-1:0]            rp_raw;
    logic [RPW-1:0]            rp;
    logic [AW-1:0]             rd_idx0;
    logic [AW-1:0]             rd_idx1;
    logic signed [SB+1:0]      fb_sum;
    logic [SB-1:0]             wr_data;
    logic                      wr_en;
    logic [SB-1:0]             rd_data0;
    logic [SB-1:0]             rd_data1;
    logic signed [SB-1:0]      s0;
    logic signed [SB-1:0]      s1;
    logic signed [SB:0]        diff;
    logic signed [SB+9:0]      iprod;
    logic signed [SB+2:0]      wet_full;
    logic signed [SB-1:0]      wet;
    logic signed [SB+17:0]     wet_prod;
    logic signed [SB+18:0]     mix_sum;
    logic signed [SB+2:0]      mix_sh;
    logic [SB-1:0]             mix_sat;
    logic                      out_free;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);
    assign out_free      = !out_valid_reg || m_axis_tready;

    // delay and feedback products (S_DLY)
    always_comb
    begin
        dprod     = $signed({1'b0, depth_reg}) * mod_reg;
        fbprod    = last_reg * $signed({1'b0, gain_reg});
        dry_share = 18'sd65536 - $signed({1'b0, wet_mix_reg});
        dry_prod  = audio_reg * dry_share;
    end

    // read position and feedback write (S_ADDR)
    always_comb
    begin
        delay_sum = DSW'($signed({1'b0, center_reg})) + DSW'(dsh_reg);
        if (delay_sum < 0)
        begin
            delay_clamp = '0;
        end
        else if (delay_sum > MAX_DELAY)
        begin
            delay_clamp = MAX_DELAY;
        end
        else
        begin
            delay_clamp = delay_sum;
        end

        rp_raw = {1'b0, wp_reg, {FRAC_BITS{1'b0}}} - delay_clamp[RPW-1:0];
        rp     = rp_raw[RPW-1] ? rp_raw + STORE_SPAN : rp_raw;

        rd_idx0 = rp[AW+FRAC_BITS-1:FRAC_BITS];
        rd_idx1 = (rd_idx0 == LAST_IDX) ? '0 : rd_idx0 + 1'b1;

        fb_sum = (SB+2)'(audio_reg) + (SB+2)'(fbsh_reg);
        if (fb_sum > FB_MAX)
        begin
            wr_data = FB_MAX[SB-1:0];
        end
        else if (fb_sum < FB_MIN)
        begin
            wr_data = FB_MIN[SB-1:0];
        end
        else
        begin
            wr_data = fb_sum[SB-1:0];
        end
        wr_en = (state_reg == S_ADDR);
    end

    mfdl_ram #(
        .WIDTH (SB),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (wp_reg),
        .wdata   (wr_data),
        .raddr_a (rd_idx0),
        .raddr_b (rd_idx1),
        .rdata_a (rd_data0),
        .rdata_b (rd_data1)
    );

    // interpolation, wet product and mix
    always_comb
    begin
        // entries never written yet read as zero
        s0    = v0_reg ? $signed(rd_data0) : '0;
        s1    = v1_reg ? $signed(rd_data1) : '0;
        diff  = (SB+1)'(s1) - (SB+1)'(s0);
        iprod = diff * $signed({1'b0, frac_reg});

        wet_full = (SB+3)'(s0_reg) + (SB+3)'(iprod_reg >>> FRAC_BITS);
        wet      = wet_full[SB-1:0];
        wet_prod = wet * $signed({1'b0, wet_mix_reg});

        mix_sum = (SB+19)'(dry_prod_reg) + (SB+19)'(wet_prod_reg);
        mix_sh  = mix_sum[SB+18:16];
        if (mix_sh > MIX_MAX)
        begin
            mix_sat = MIX_MAX[SB-1:0];
        end
        else if (mix_sh < MIX_MIN)
        begin
            mix_sat = MIX_MIN[SB-1:0];
        end
        else
        begin
            mix_sat = mix_sh[SB-1:0];
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg  <= '0;
            depth_reg   <= '0;
            gain_reg    <= '0;
            wet_mix_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DELAY_CENTER:  center_reg  <= cfg_data[CENTER_BITS-1:0];
                CFG_DELAY_DEPTH:   depth_reg   <= cfg_data[DEPTH_BITS-1:0];
                CFG_FEEDBACK_GAIN: gain_reg    <= cfg_data[GAIN_BITS-1:0];
                CFG_WET_MIX:       wet_mix_reg <= cfg_data[WET_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= S_DLY;
                    end
                end
                S_DLY:
                begin
                    state_reg <= S_ADDR;
                end
                S_ADDR:
                begin
                    wp_reg <= (wp_reg == LAST_IDX) ? '0 : wp_reg + 1'b1;
                    if (wp_reg == LAST_IDX)
                    begin
                        wrapped_reg <= 1'b1;
                    end
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_WET;
                end
                S_WET:
                begin
                    last_reg  <= wet;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            audio_reg <= $signed(s_axis_tdata[SB-1:0]);
            mod_reg   <= $signed(s_axis_tdata[SB+MOD_BITS-1:SB]);
        end
        if (state_reg == S_DLY)
        begin
            dsh_reg      <= dprod[34:15];
            fbsh_reg     <= fbprod[SB+16:16];
            dry_prod_reg <= dry_prod;
        end
        if (state_reg == S_ADDR)
        begin
            v0_reg   <= wrapped_reg || (rd_idx0 < wp_reg);
            v1_reg   <= wrapped_reg || (rd_idx1 < wp_reg);
            frac_reg <= rp[FRAC_BITS-1:0];
        end
        if (state_reg == S_RD)
        begin
            s0_reg    <= s0;
            iprod_reg <= iprod;
        end
        if (state_reg == S_WET)
        begin
            wet_prod_reg <= wet_prod;
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_data_reg <= mix_sat;
        end
    end

    // checks
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_DLY) && !s_axis_tready)
        else $error("item accepted while another is in flight");

    a_delay_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADDR) |-> (delay_clamp >= 0) && (delay_clamp <= MAX_DELAY)
            && (32'(rd_idx0) < STORE_DEPTH) && (32'(rd_idx1) < STORE_DEPTH)
            && (32'(wp_reg) < STORE_DEPTH))
        else $error("store access out of range");

    a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(wrapped_reg))
        else $error("fill flag cleared after wrap");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) && out_free |=> m_axis_tvalid && (state_reg == S_IDLE))
        else $error("finished result not presented");

endmodule
